@@ src/rcs_pkg.sv @@
// ----------------------------------------------------------------------------
// RC stick package
// Shared constants, types and helper functions for the stick setpoint and
// arming block.
// ----------------------------------------------------------------------------
package rcs_pkg;

    // Width of the tick counter used for the hold timer.
    localparam int TIME_WIDTH = 32;

    localparam int PULSE_W    = 12;
    localparam int CLAMP_W    = 11;
    localparam int MAX_W      = 11;
    localparam int ANGLE_W    = 8;
    localparam int HOLD_W     = 16;
    localparam int IN_TIME_W  = 32;
    localparam int SETP_W     = 16;
    localparam int MAG_W      = 9;
    localparam int PROD_W     = MAG_W + MAX_W;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Number of scaled setpoint channels.
    localparam int NCH = 5;

    localparam logic [CLAMP_W-1:0] PULSE_MIN = 11'd1000;
    localparam logic [CLAMP_W-1:0] PULSE_MAX = 11'd2000;
    localparam logic [CLAMP_W-1:0] PULSE_MID = 11'd1500;

    localparam logic [PULSE_W-1:0] STICK_VALID_LO  = 12'd750;
    localparam logic [PULSE_W-1:0] STICK_LOW_EDGE  = 12'd1050;
    localparam logic [PULSE_W-1:0] STICK_HIGH_EDGE = 12'd1950;
    localparam logic [PULSE_W-1:0] STICK_VALID_HI  = 12'd2250;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] CFG_ROLL_MAX_ANGLE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PITCH_MAX_ANGLE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROLL_MAX_RATE   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PITCH_MAX_RATE  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_YAW_MAX_RATE    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_TICKS      = 3'd5;

    localparam logic [ANGLE_W-1:0] RST_MAX_ANGLE  = 8'd30;
    localparam logic [MAX_W-1:0]   RST_MAX_RATE   = 11'd200;
    localparam logic [HOLD_W-1:0]  RST_HOLD_TICKS = 16'd500;

    // Division by 125 as a multiplication by a rounded-up reciprocal. The
    // error term times the largest dividend stays below 2^RECIP_SHIFT, so the
    // quotient is exact over the whole operand range.
    localparam int DIV_IN_W    = PROD_W + 2;
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 24;
    localparam int DIV_PROD_W  = DIV_IN_W + RECIP_W;
    localparam int QUOT_W      = 15;
    localparam logic [RECIP_W-1:0]  RECIP_125   = 24'd8589935;
    localparam logic [DIV_IN_W-1:0] ROUND_BIAS  = 22'd62;

    typedef struct packed {
        logic armed;
        logic enable_failsafe;
        logic disable_failsafe;
    } arm_flags_t;

    function automatic logic [CLAMP_W-1:0] clamp_pulse(input logic [PULSE_W-1:0] p);
        logic [CLAMP_W-1:0] r;
        if (p < PULSE_W'(PULSE_MIN)) begin
            r = PULSE_MIN;
        end else if (p > PULSE_W'(PULSE_MAX)) begin
            r = PULSE_MAX;
        end else begin
            r = p[CLAMP_W-1:0];
        end
        return r;
    endfunction

    function automatic logic in_open(input logic [PULSE_W-1:0] v,
                                     input logic [PULSE_W-1:0] lo,
                                     input logic [PULSE_W-1:0] hi);
        return (v > lo) && (v < hi);
    endfunction

endpackage

@@ src/rcs_stick_mul.sv @@
// ----------------------------------------------------------------------------
// RC stick magnitude multiplier
// Clamps one stick pulse, takes its distance from centre and multiplies it by
// the configured full-stick value. The sign is carried separately.
// ----------------------------------------------------------------------------
module rcs_stick_mul (
    input  logic [rcs_pkg::PULSE_W-1:0] pulse,
    input  logic [rcs_pkg::MAX_W-1:0]   max_val,
    input  logic                        invert,
    output logic [rcs_pkg::PROD_W-1:0]  prod,
    output logic                        neg
);
    import rcs_pkg::*;

    logic [CLAMP_W-1:0] clamped;
    logic [MAG_W-1:0]   mag;
    logic               below_mid;

    always_comb begin
        clamped   = clamp_pulse(pulse);
        below_mid = clamped < PULSE_MID;
        if (below_mid) begin
            mag = MAG_W'(PULSE_MID - clamped);
        end else begin
            mag = MAG_W'(clamped - PULSE_MID);
        end
        prod = PROD_W'(mag) * PROD_W'(max_val);
        neg  = below_mid ^ invert;
    end

endmodule

@@ src/rcs_round_div.sv @@
// ----------------------------------------------------------------------------
// RC stick rounding divider
// Turns a stick product into a signed setpoint in sixteenths: the product is
// scaled by 4/125, rounded half away from zero, and the sign applied.
// ----------------------------------------------------------------------------
module rcs_round_div (
    input  logic [rcs_pkg::PROD_W-1:0]        prod,
    input  logic                              neg,
    output logic signed [rcs_pkg::SETP_W-1:0] setpoint
);
    import rcs_pkg::*;

    logic [DIV_IN_W-1:0]   dividend;
    logic [DIV_PROD_W-1:0] scaled;
    logic [QUOT_W-1:0]     quot;

    always_comb begin
        // Adding 62 before the floor division by 125 gives round-half-up on 4p/125.
        dividend = {prod, 2'b00} + ROUND_BIAS;
        scaled   = DIV_PROD_W'(dividend) * DIV_PROD_W'(RECIP_125);
        quot     = scaled[RECIP_SHIFT +: QUOT_W];
        if (neg) begin
            setpoint = -$signed(SETP_W'(quot));
        end else begin
            setpoint = $signed(SETP_W'(quot));
        end
    end

endmodule

@@ src/rcs_arming.sv @@
// ----------------------------------------------------------------------------
// RC stick arming logic
// Holds the armed flag and the hold timer, and updates them once for every
// frame that leaves the input stage.
// ----------------------------------------------------------------------------
module rcs_arming (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step,
    input  logic [rcs_pkg::PULSE_W-1:0]    throttle_pulse,
    input  logic [rcs_pkg::PULSE_W-1:0]    yaw_pulse,
    input  logic [rcs_pkg::IN_TIME_W-1:0]  time_now,
    input  logic                           failsafe_tripped,
    input  logic [rcs_pkg::HOLD_W-1:0]     hold_ticks,
    output rcs_pkg::arm_flags_t            flags
);
    import rcs_pkg::*;

    logic                  armed_reg,   armed_next;
    logic                  running_reg, running_next;
    logic [TIME_WIDTH-1:0] start_reg,   start_next;

    logic                  thr_low, yaw_low, yaw_high, gesture, held;
    logic [TIME_WIDTH-1:0] now, elapsed;

    always_comb begin
        now      = TIME_WIDTH'(time_now);
        thr_low  = in_open(throttle_pulse, STICK_VALID_LO, STICK_LOW_EDGE);
        yaw_low  = in_open(yaw_pulse, STICK_VALID_LO, STICK_LOW_EDGE);
        yaw_high = in_open(yaw_pulse, STICK_HIGH_EDGE, STICK_VALID_HI);
        gesture  = thr_low && (yaw_low || yaw_high);

        // A timer that is not yet running starts at this frame, so it has
        // zero elapsed time. Moving yaw between the ends keeps it running.
        start_next   = (gesture && !running_reg) ? now : start_reg;
        running_next = gesture;
        elapsed      = now - start_next;
        held         = gesture && (elapsed > TIME_WIDTH'(hold_ticks));

        armed_next            = armed_reg;
        flags.enable_failsafe  = 1'b0;
        flags.disable_failsafe = 1'b0;
        if (held) begin
            if (yaw_low) begin
                if (armed_reg) begin
                    armed_next             = 1'b0;
                    flags.disable_failsafe = 1'b1;
                end
            end else if (!failsafe_tripped && !armed_reg) begin
                armed_next            = 1'b1;
                flags.enable_failsafe = 1'b1;
            end
        end
        flags.armed = armed_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg   <= 1'b0;
            running_reg <= 1'b0;
            start_reg   <= '0;
        end else if (step) begin
            armed_reg   <= armed_next;
            running_reg <= running_next;
            start_reg   <= start_next;
        end
    end

endmodule

@@ src/rc_stick_setpoint_and_arming_top.sv @@
// ----------------------------------------------------------------------------
// RC stick setpoint and arming, top level
// Clamps and scales one receiver frame into setpoints and runs the stick
// arming gesture.
// ----------------------------------------------------------------------------
// The block takes one frame in every clock cycle while the output side is
// not stalled. A frame is registered at the input, then the stick products
// and the arming decision are registered, then the reciprocal multiplication
// by 1/125 fills the output register. Backpressure on the result channel
// stalls the pipeline stage by stage, so up to three frames can be held
// inside. Configuration registers are written through a plain write port
// and must only change while no frame is in flight.
module rc_stick_setpoint_and_arming_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_wr_en,
    input  logic [rcs_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [rcs_pkg::CFG_DATA_W-1:0]       cfg_wdata,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [rcs_pkg::PULSE_W-1:0]          s_throttle_pulse,
    input  logic [rcs_pkg::PULSE_W-1:0]          s_roll_pulse,
    input  logic [rcs_pkg::PULSE_W-1:0]          s_pitch_pulse,
    input  logic [rcs_pkg::PULSE_W-1:0]          s_yaw_pulse,
    input  logic [rcs_pkg::IN_TIME_W-1:0]        s_time_now,
    input  logic                                 s_failsafe_tripped,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [rcs_pkg::CLAMP_W-1:0]          m_throttle_out,
    output logic signed [rcs_pkg::SETP_W-1:0]    m_roll_angle_out,
    output logic signed [rcs_pkg::SETP_W-1:0]    m_pitch_angle_out,
    output logic signed [rcs_pkg::SETP_W-1:0]    m_roll_rate_out,
    output logic signed [rcs_pkg::SETP_W-1:0]    m_pitch_rate_out,
    output logic signed [rcs_pkg::SETP_W-1:0]    m_yaw_rate_out,
    output logic                                 m_armed,
    output logic                                 m_enable_failsafe,
    output logic                                 m_disable_failsafe
);
    import rcs_pkg::*;

    // Configuration registers.
    logic [ANGLE_W-1:0] roll_max_angle_reg, pitch_max_angle_reg;
    logic [MAX_W-1:0]   roll_max_rate_reg, pitch_max_rate_reg, yaw_max_rate_reg;
    logic [HOLD_W-1:0]  hold_ticks_reg;

    // Input stage.
    logic                 s1_valid_reg;
    logic [PULSE_W-1:0]   s1_thr_reg, s1_roll_reg, s1_pitch_reg, s1_yaw_reg;
    logic [IN_TIME_W-1:0] s1_time_reg;
    logic                 s1_fs_reg;

    // Product stage.
    logic                 s2_valid_reg;
    logic [CLAMP_W-1:0]   s2_thr_reg;
    logic [PROD_W-1:0]    s2_prod_reg [NCH];
    logic [NCH-1:0]       s2_neg_reg;
    arm_flags_t           s2_flags_reg;

    // Output stage.
    logic                 m_valid_reg;

    logic                 s1_adv, s2_adv, s2_free, s3_free;
    logic [PULSE_W-1:0]   ch_pulse [NCH];
    logic [MAX_W-1:0]     ch_max   [NCH];
    logic [NCH-1:0]       ch_inv;
    logic [PROD_W-1:0]    ch_prod  [NCH];
    logic [NCH-1:0]       ch_neg;
    logic signed [SETP_W-1:0] ch_setp [NCH];
    arm_flags_t           arm_flags;

    assign s3_free = !m_valid_reg || m_ready;
    assign s2_adv  = s2_valid_reg && s3_free;
    assign s2_free = !s2_valid_reg || s2_adv;
    assign s1_adv  = s1_valid_reg && s2_free;
    assign s_ready = !s1_valid_reg || s1_adv;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roll_max_angle_reg  <= RST_MAX_ANGLE;
            pitch_max_angle_reg <= RST_MAX_ANGLE;
            roll_max_rate_reg   <= RST_MAX_RATE;
            pitch_max_rate_reg  <= RST_MAX_RATE;
            yaw_max_rate_reg    <= RST_MAX_RATE;
            hold_ticks_reg      <= RST_HOLD_TICKS;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_ROLL_MAX_ANGLE:  roll_max_angle_reg  <= cfg_wdata[ANGLE_W-1:0];
                CFG_PITCH_MAX_ANGLE: pitch_max_angle_reg <= cfg_wdata[ANGLE_W-1:0];
                CFG_ROLL_MAX_RATE:   roll_max_rate_reg   <= cfg_wdata[MAX_W-1:0];
                CFG_PITCH_MAX_RATE:  pitch_max_rate_reg  <= cfg_wdata[MAX_W-1:0];
                CFG_YAW_MAX_RATE:    yaw_max_rate_reg    <= cfg_wdata[MAX_W-1:0];
                CFG_HOLD_TICKS:      hold_ticks_reg      <= cfg_wdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s2_free) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free) begin
                m_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_thr_reg   <= s_throttle_pulse;
            s1_roll_reg  <= s_roll_pulse;
            s1_pitch_reg <= s_pitch_pulse;
            s1_yaw_reg   <= s_yaw_pulse;
            s1_time_reg  <= s_time_now;
            s1_fs_reg    <= s_failsafe_tripped;
        end
    end

    always_comb begin
        ch_pulse[0] = s1_roll_reg;   ch_max[0] = MAX_W'(roll_max_angle_reg);
        ch_pulse[1] = s1_pitch_reg;  ch_max[1] = MAX_W'(pitch_max_angle_reg);
        ch_pulse[2] = s1_roll_reg;   ch_max[2] = roll_max_rate_reg;
        ch_pulse[3] = s1_pitch_reg;  ch_max[3] = pitch_max_rate_reg;
        ch_pulse[4] = s1_yaw_reg;    ch_max[4] = yaw_max_rate_reg;
        ch_inv      = 5'b10000;
    end

    for (genvar i = 0; i < NCH; i++) begin : g_ch
        rcs_stick_mul u_mul (
            .pulse   (ch_pulse[i]),
            .max_val (ch_max[i]),
            .invert  (ch_inv[i]),
            .prod    (ch_prod[i]),
            .neg     (ch_neg[i])
        );

        rcs_round_div u_div (
            .prod     (s2_prod_reg[i]),
            .neg      (s2_neg_reg[i]),
            .setpoint (ch_setp[i])
        );
    end

    rcs_arming u_arming (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step             (s1_adv),
        .throttle_pulse   (s1_thr_reg),
        .yaw_pulse        (s1_yaw_reg),
        .time_now         (s1_time_reg),
        .failsafe_tripped (s1_fs_reg),
        .hold_ticks       (hold_ticks_reg),
        .flags            (arm_flags)
    );

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s2_thr_reg   <= clamp_pulse(s1_thr_reg);
            s2_prod_reg  <= ch_prod;
            s2_neg_reg   <= ch_neg;
            s2_flags_reg <= arm_flags;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            m_throttle_out     <= s2_thr_reg;
            m_roll_angle_out   <= ch_setp[0];
            m_pitch_angle_out  <= ch_setp[1];
            m_roll_rate_out    <= ch_setp[2];
            m_pitch_rate_out   <= ch_setp[3];
            m_yaw_rate_out     <= ch_setp[4];
            m_armed            <= s2_flags_reg.armed;
            m_enable_failsafe  <= s2_flags_reg.enable_failsafe;
            m_disable_failsafe <= s2_flags_reg.disable_failsafe;
        end
    end

endmodule

@@ src/rcs_checker.sv @@
// ----------------------------------------------------------------------------
// RC stick port checker
// Watches the top level's ports for consistency of the arming flags, the
// throttle range and the result handshake.
// ----------------------------------------------------------------------------
module rcs_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic [rcs_pkg::CLAMP_W-1:0]          m_throttle_out,
    input  logic                                 m_armed,
    input  logic                                 m_enable_failsafe,
    input  logic                                 m_disable_failsafe
);
    import rcs_pkg::*;

    // A transaction cannot both arm and disarm the craft.
    a_single_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_enable_failsafe && m_disable_failsafe))
        else $error("arm and disarm flagged in one transaction");

    a_arm_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_enable_failsafe) |-> m_armed)
        else $error("arming transaction does not report armed");

    a_disarm_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_disable_failsafe) |-> !m_armed)
        else $error("disarming transaction still reports armed");

    a_throttle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_throttle_out >= PULSE_MIN) && (m_throttle_out <= PULSE_MAX))
        else $error("throttle outside clamp range");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result withdrawn before acceptance");

endmodule

bind rc_stick_setpoint_and_arming_top rcs_checker u_rcs_checker (.*);
